### hdl/timed_hbridge_drive_top_macros.svh
// Assertion macros for the H-bridge drive block.
// Included by the top level; no other dependencies.
`ifndef TIMED_HBRIDGE_DRIVE_TOP_MACROS_SVH
`define TIMED_HBRIDGE_DRIVE_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset
`define THBD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define THBD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/thbd_pkg.sv
// Shared widths, codes, reset values and structs of the H-bridge drive block.
// No dependencies; used by the register, move, control and top files of the block.
package thbd_pkg;

    localparam int unsigned SPEED_W  = 16;
    localparam int unsigned AMOUNT_W = 16;
    localparam int unsigned MAXAMT_W = 15;
    localparam int unsigned RATE_W   = 24;
    localparam int unsigned HOME_W   = 32;
    localparam int unsigned DEAD_W   = 16;
    localparam int unsigned DUTY_W   = 8;
    localparam int unsigned FRAC_W   = 8;
    localparam int unsigned PROD_W   = MAXAMT_W + RATE_W;
    localparam int unsigned DRAW_W   = PROD_W - FRAC_W;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned CFG_ADDR_W = 5;

    localparam logic [DUTY_W-1:0] DUTY_MAX = {DUTY_W{1'b1}};

    // Register reset values
    localparam logic                RST_ENABLE      = 1'b1;
    localparam logic [MAXAMT_W-1:0] RST_MAX_AMOUNT  = 15'd32767;
    localparam logic [RATE_W-1:0]   RST_US_PER_UNIT = 24'd1000000;
    localparam logic [HOME_W-1:0]   RST_HOME_US     = 32'd0;
    localparam logic [DEAD_W-1:0]   RST_DEAD_TICKS  = 16'd500;

    typedef enum logic [1:0] {
        MODE_DRIVE = 2'd0,
        MODE_MOVE  = 2'd1,
        MODE_STOP  = 2'd2,
        MODE_TICK  = 2'd3
    } t_mode;

    typedef struct packed {
        logic                enable;
        logic [MAXAMT_W-1:0] max_amount;
        logic [RATE_W-1:0]   us_per_unit;
        logic [HOME_W-1:0]   home_us;
        logic [DEAD_W-1:0]   dead_ticks;
    } t_cfg;

    // Item after speed clamp and move-time multiply
    typedef struct packed {
        t_mode             mode;
        logic [DUTY_W-1:0] speed;
        logic              direction;
        logic [DRAW_W-1:0] draw;
        logic              add_home;
    } t_move_item;

endpackage

### hdl/thbd_if.sv
// Valid/ready channels of the H-bridge drive block: command in, bridge state out.
// Depends on nothing but the payload widths written here.
interface thbd_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         mode;
    logic signed [15:0] speed;
    logic               direction;
    logic signed [15:0] amount;
    logic               add_home;

    modport source (output valid, mode, speed, direction, amount, add_home, input ready);
    modport sink   (input valid, mode, speed, direction, amount, add_home, output ready);
endinterface

interface thbd_out_if;
    logic       valid;
    logic       ready;
    logic       line_one;
    logic       line_two;
    logic [7:0] duty;
    logic       dead_time_active;
    logic       move_active;

    modport source (output valid, line_one, line_two, duty, dead_time_active, move_active,
                    input ready);
    modport sink   (input valid, line_one, line_two, duty, dead_time_active, move_active,
                    output ready);
endinterface

### hdl/thbd_regs.sv
// APB-style configuration registers of the H-bridge drive block.
// Depends on thbd_pkg.
module thbd_regs
    import thbd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    typedef enum logic [2:0] {
        REG_ENABLE      = 3'd0,
        REG_MAX_AMOUNT  = 3'd1,
        REG_US_PER_UNIT = 3'd2,
        REG_HOME_US     = 3'd3,
        REG_DEAD_TICKS  = 3'd4
    } t_reg_idx;

    t_cfg       r_cfg;
    logic [2:0] w_idx;
    logic       w_wr;

    assign w_idx  = paddr[CFG_ADDR_W-1:2];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // Write on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable      <= RST_ENABLE;
            r_cfg.max_amount  <= RST_MAX_AMOUNT;
            r_cfg.us_per_unit <= RST_US_PER_UNIT;
            r_cfg.home_us     <= RST_HOME_US;
            r_cfg.dead_ticks  <= RST_DEAD_TICKS;
        end else if (w_wr) begin
            case (w_idx)
                REG_ENABLE:      r_cfg.enable      <= pwdata[0];
                REG_MAX_AMOUNT:  r_cfg.max_amount  <= pwdata[MAXAMT_W-1:0];
                REG_US_PER_UNIT: r_cfg.us_per_unit <= pwdata[RATE_W-1:0];
                REG_HOME_US:     r_cfg.home_us     <= pwdata[HOME_W-1:0];
                REG_DEAD_TICKS:  r_cfg.dead_ticks  <= pwdata[DEAD_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        case (w_idx)
            REG_ENABLE:      prdata = CFG_DATA_W'(r_cfg.enable);
            REG_MAX_AMOUNT:  prdata = CFG_DATA_W'(r_cfg.max_amount);
            REG_US_PER_UNIT: prdata = CFG_DATA_W'(r_cfg.us_per_unit);
            REG_HOME_US:     prdata = CFG_DATA_W'(r_cfg.home_us);
            REG_DEAD_TICKS:  prdata = CFG_DATA_W'(r_cfg.dead_ticks);
            default:         prdata = '0;
        endcase
    end

endmodule

### hdl/thbd_move.sv
// Input register, speed clamp and move-time multiply of the H-bridge drive block.
// Depends on thbd_pkg and thbd_if.
module thbd_move
    import thbd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    thbd_in_if.sink             i_in,
    input  logic [MAXAMT_W-1:0] i_max_amount,
    input  logic [RATE_W-1:0]   i_us_per_unit,
    output t_move_item          o_item,
    output logic                o_valid,
    input  logic                i_ready
);

    logic                       r_s1_valid;
    logic [1:0]                 r_s1_mode;
    logic signed [SPEED_W-1:0]  r_s1_speed;
    logic                       r_s1_direction;
    logic signed [AMOUNT_W-1:0] r_s1_amount;
    logic                       r_s1_add_home;
    logic                       r_s2_valid;
    t_move_item                 r_s2;

    logic                w_s1_adv;
    logic [MAXAMT_W-1:0] w_amt;
    logic [PROD_W-1:0]   w_prod;
    logic [DUTY_W-1:0]   w_speed;

    assign w_s1_adv   = !r_s2_valid || i_ready;
    assign i_in.ready = !r_s1_valid || w_s1_adv;
    assign o_item     = r_s2;
    assign o_valid    = r_s2_valid;

    // Clamp amount to 0..max; non-positive gives zero time
    always_comb begin
        if (r_s1_amount[AMOUNT_W-1]) begin
            w_amt = '0;
        end else if (r_s1_amount[MAXAMT_W-1:0] > i_max_amount) begin
            w_amt = i_max_amount;
        end else begin
            w_amt = r_s1_amount[MAXAMT_W-1:0];
        end
    end

    assign w_prod = PROD_W'(w_amt) * PROD_W'(i_us_per_unit);

    // Clamp speed to 0..255
    always_comb begin
        if (r_s1_speed[SPEED_W-1]) begin
            w_speed = '0;
        end else if (r_s1_speed[SPEED_W-2:DUTY_W] != '0) begin
            w_speed = DUTY_MAX;
        end else begin
            w_speed = r_s1_speed[DUTY_W-1:0];
        end
    end

    // Capture a transfer into the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready) begin
            r_s1_mode      <= i_in.mode;
            r_s1_speed     <= i_in.speed;
            r_s1_direction <= i_in.direction;
            r_s1_amount    <= i_in.amount;
            r_s1_add_home  <= i_in.add_home;
        end
    end

    // Advance into the product register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_s1_adv) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            r_s2.mode      <= t_mode'(r_s1_mode);
            r_s2.speed     <= w_speed;
            r_s2.direction <= r_s1_direction;
            r_s2.draw      <= w_prod[PROD_W-1:FRAC_W];
            r_s2.add_home  <= r_s1_add_home;
        end
    end

endmodule

### hdl/thbd_ctrl.sv
// Bridge state update (dead time, move countdown) and result register.
// Depends on thbd_pkg and thbd_if.
module thbd_ctrl
    import thbd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  t_move_item i_item,
    input  logic       i_valid,
    output logic       o_ready,
    thbd_out_if.source o_out
);

    typedef enum logic [1:0] {
        BR_COAST = 2'd0,
        BR_ONE   = 2'd1,
        BR_TWO   = 2'd2
    } t_bridge;

    t_bridge           r_bridge,        n_bridge;
    logic              r_last_dir,      n_last_dir;
    logic [DUTY_W-1:0] r_last_speed,    n_last_speed;
    logic [DEAD_W-1:0] r_dead_count,    n_dead_count;
    logic [DUTY_W-1:0] r_pend_speed,    n_pend_speed;
    logic              r_pend_dir,      n_pend_dir;
    logic [HOME_W-1:0] r_move_count,    n_move_count;
    logic              r_move_armed,    n_move_armed;
    logic              r_out_valid;
    logic              r_line_one,      n_line_one;
    logic              r_line_two,      n_line_two;
    logic [DUTY_W-1:0] r_duty,          n_duty;
    logic              r_dead_active,   n_dead_active;

    logic [HOME_W:0]   w_sum;
    logic [HOME_W-1:0] w_total;
    logic              w_fire;
    logic              w_zero_move;
    logic              w_clear;

    assign o_ready = !r_out_valid || o_out.ready;
    assign w_fire  = i_valid && o_ready;

    // Move time plus optional homing time, saturated
    assign w_sum = (HOME_W+1)'(i_item.draw)
                 + (HOME_W+1)'(i_item.add_home ? i_cfg.home_us : '0);
    assign w_total = w_sum[HOME_W] ? {HOME_W{1'b1}} : w_sum[HOME_W-1:0];
    assign w_zero_move = (i_item.mode == MODE_MOVE) && (w_total == '0);

    // Next state
    always_comb begin
        n_bridge     = r_bridge;
        n_last_dir   = r_last_dir;
        n_last_speed = r_last_speed;
        n_dead_count = r_dead_count;
        n_pend_speed = r_pend_speed;
        n_pend_dir   = r_pend_dir;
        n_move_count = r_move_count;
        n_move_armed = r_move_armed;
        w_clear      = 1'b0;
        if (w_fire && i_cfg.enable) begin
            if (i_item.mode == MODE_STOP || w_zero_move) begin
                w_clear = 1'b1;
            end else if (i_item.mode == MODE_DRIVE || i_item.mode == MODE_MOVE) begin
                if (r_dead_count != '0) begin
                    // replace the pending command, keep counting
                    n_pend_speed = i_item.speed;
                    n_pend_dir   = i_item.direction;
                end else if (i_item.direction != r_last_dir && r_last_speed != '0 &&
                             i_cfg.dead_ticks != '0) begin
                    // reversal of a running motor: coast first
                    n_bridge     = BR_COAST;
                    n_dead_count = i_cfg.dead_ticks;
                    n_pend_speed = i_item.speed;
                    n_pend_dir   = i_item.direction;
                end else begin
                    n_bridge     = i_item.direction ? BR_ONE : BR_TWO;
                    n_last_speed = i_item.speed;
                    n_last_dir   = i_item.direction;
                end
                if (i_item.mode == MODE_MOVE) begin
                    n_move_count = w_total;
                    n_move_armed = 1'b1;
                end
            end else begin
                // one microsecond tick
                if (r_dead_count != '0) begin
                    n_dead_count = r_dead_count - 1'b1;
                    if (r_dead_count == DEAD_W'(1)) begin
                        n_bridge     = r_pend_dir ? BR_ONE : BR_TWO;
                        n_last_speed = r_pend_speed;
                        n_last_dir   = r_pend_dir;
                    end
                end else if (r_move_armed) begin
                    if (r_move_count <= HOME_W'(1)) begin
                        w_clear = 1'b1;
                    end else begin
                        n_move_count = r_move_count - 1'b1;
                    end
                end
            end
        end
        if (w_clear) begin
            n_bridge     = BR_COAST;
            n_last_speed = '0;
            n_dead_count = '0;
            n_pend_speed = '0;
            n_pend_dir   = 1'b0;
            n_move_count = '0;
            n_move_armed = 1'b0;
        end
    end

    // Result fields from the updated state
    always_comb begin
        n_dead_active = (n_dead_count != '0);
        n_line_one    = !n_dead_active && (n_bridge == BR_ONE);
        n_line_two    = !n_dead_active && (n_bridge == BR_TWO);
        n_duty        = (n_line_one || n_line_two) ? n_last_speed : '0;
    end

    // Hold state and the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bridge      <= BR_COAST;
            r_last_dir    <= 1'b0;
            r_last_speed  <= '0;
            r_dead_count  <= '0;
            r_pend_speed  <= '0;
            r_pend_dir    <= 1'b0;
            r_move_count  <= '0;
            r_move_armed  <= 1'b0;
            r_out_valid   <= 1'b0;
            r_line_one    <= 1'b0;
            r_line_two    <= 1'b0;
            r_duty        <= '0;
            r_dead_active <= 1'b0;
        end else begin
            if (w_fire) begin
                r_bridge      <= n_bridge;
                r_last_dir    <= n_last_dir;
                r_last_speed  <= n_last_speed;
                r_dead_count  <= n_dead_count;
                r_pend_speed  <= n_pend_speed;
                r_pend_dir    <= n_pend_dir;
                r_move_count  <= n_move_count;
                r_move_armed  <= n_move_armed;
                r_line_one    <= n_line_one;
                r_line_two    <= n_line_two;
                r_duty        <= n_duty;
                r_dead_active <= n_dead_active;
                r_out_valid   <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid   <= 1'b0;
            end
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.line_one         = r_line_one;
    assign o_out.line_two         = r_line_two;
    assign o_out.duty             = r_duty;
    assign o_out.dead_time_active = r_dead_active;
    assign o_out.move_active      = r_move_armed;

endmodule

### hdl/timed_hbridge_drive_top.sv
// H-bridge drive with reversal dead time and timed moves. Each command or tick
// transfer yields exactly one result showing the bridge lines, duty, dead-time and
// move flags after that item. One item is accepted every clock cycle unless the
// result side stalls. Items pass the input register, move-time multiply register,
// state-update and result register. The 15x24 multiply has its own register stage;
// the per-item state update (dead-time and move counters) is the loop that sets
// rate. The user must write configuration through the APB-style port only while no
// item is in flight; the block does not enforce this.
`include "timed_hbridge_drive_top_macros.svh"

module timed_hbridge_drive_top
    import thbd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    thbd_in_if.sink               i_in,
    thbd_out_if.source            o_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    t_cfg       w_cfg;
    t_move_item w_item;
    logic       w_item_valid;
    logic       w_item_ready;

    // Configuration registers
    thbd_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Input register and move-time multiply
    thbd_move u_move (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (i_in),
        .i_max_amount  (w_cfg.max_amount),
        .i_us_per_unit (w_cfg.us_per_unit),
        .o_item        (w_item),
        .o_valid       (w_item_valid),
        .i_ready       (w_item_ready)
    );

    // State update and result register
    thbd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_item  (w_item),
        .i_valid (w_item_valid),
        .o_ready (w_item_ready),
        .o_out   (o_out)
    );

    // Dead time never drives the bridge
    `THBD_ASSERT_SAME(a_dead_coasts, i_clk, i_rst_n,
        o_out.valid && o_out.dead_time_active,
        !o_out.line_one && !o_out.line_two && o_out.duty == '0,
        "bridge driven during dead time")

    // Non-zero duty goes with exactly one active line
    `THBD_ASSERT_SAME(a_duty_one_line, i_clk, i_rst_n,
        o_out.valid && o_out.duty != '0,
        o_out.line_one != o_out.line_two,
        "duty applied without exactly one bridge line")

    // An item leaving the product stage shows up as a result next cycle
    `THBD_ASSERT_NEXT(a_item_to_result, i_clk, i_rst_n,
        w_item_valid && w_item_ready,
        o_out.valid,
        "state update did not produce a result")

endmodule

### tb/sv/thbd_tb_pkg.sv
`timescale 1ns / 100ps
// Register map of the H-bridge drive configuration port, seen from the testbench.
// No dependencies; shared by the checker and the testbench top.
package thbd_tb_pkg;

    // Register indexes; the byte address is four times the index
    typedef enum logic [2:0] {
        REG_ENABLE      = 3'd0,
        REG_MAX_AMOUNT  = 3'd1,
        REG_US_PER_UNIT = 3'd2,
        REG_HOME_US     = 3'd3,
        REG_DEAD_TICKS  = 3'd4
    } t_reg_idx;

endpackage

### tb/sv/thbd_checker.sv
`timescale 1ns / 100ps
// Scoreboard of the H-bridge drive: tracks config writes, predicts the bridge view
// for every command transfer and compares each result. Needs thbd_pkg, thbd_tb_pkg.
module thbd_checker
    import thbd_pkg::*;
    import thbd_tb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    thbd_in_if                    i_in,
    thbd_out_if                   i_out,
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic [CFG_ADDR_W-1:0] i_paddr,
    input  logic [CFG_DATA_W-1:0] i_pwdata,
    input  logic                  i_pready,
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam int unsigned TOTAL_W = HOME_W + 1;

    typedef enum logic [1:0] {
        BRIDGE_COAST = 2'd0,
        BRIDGE_ONE   = 2'd1,
        BRIDGE_TWO   = 2'd2
    } t_bridge;

    typedef struct packed {
        logic              line_one;
        logic              line_two;
        logic [DUTY_W-1:0] duty;
        logic              dead_time_active;
        logic              move_active;
    } t_bridge_view;

    // Shadow of the registers and of the drive state
    t_cfg              cfg;
    logic              last_dir;
    logic [DUTY_W-1:0] last_duty;
    t_bridge           bridge;
    logic [DEAD_W-1:0] dead_left;
    logic [DUTY_W-1:0] pend_duty;
    logic              pend_dir;
    logic [HOME_W-1:0] move_left;
    logic              move_armed;

    t_bridge_view      expected_views[$];
    int                fails;
    int                waiting;

    assign o_fail_count = fails;
    assign o_pending    = waiting;

    function automatic logic [DUTY_W-1:0] clamp_duty(logic signed [SPEED_W-1:0] spd);
        if (spd < 0)
            return '0;
        if (spd > SPEED_W'(DUTY_MAX))
            return DUTY_MAX;
        return spd[DUTY_W-1:0];
    endfunction

    // Clamp the amount, scale by the rate, drop the fraction, add homing, saturate
    function automatic logic [HOME_W-1:0] move_time_us(logic signed [AMOUNT_W-1:0] amt,
                                                       logic add_home);
        logic [MAXAMT_W-1:0] units;
        logic [PROD_W-1:0]   prod;
        logic [TOTAL_W-1:0]  total;
        units = '0;
        if (amt > 0)
            units = ($unsigned(amt) > cfg.max_amount) ? cfg.max_amount : amt[MAXAMT_W-1:0];
        prod  = PROD_W'(units) * PROD_W'(cfg.us_per_unit);
        total = TOTAL_W'(prod >> FRAC_W);
        if (add_home)
            total = total + TOTAL_W'(cfg.home_us);
        if (total[HOME_W])
            return '1;
        return total[HOME_W-1:0];
    endfunction

    function automatic void stop_all();
        bridge     = BRIDGE_COAST;
        last_duty  = '0;
        dead_left  = '0;
        pend_duty  = '0;
        pend_dir   = 1'b0;
        move_left  = '0;
        move_armed = 1'b0;
    endfunction

    function automatic void apply_cmd(logic [DUTY_W-1:0] duty, logic dir);
        bridge    = dir ? BRIDGE_ONE : BRIDGE_TWO;
        last_duty = duty;
        last_dir  = dir;
    endfunction

    function automatic void drive_cmd(logic [DUTY_W-1:0] duty, logic dir);
        // Replace the pending command while coasting
        if (dead_left != 0) begin
            pend_duty = duty;
            pend_dir  = dir;
            return;
        end
        // Coast first when reversing a running motor
        if (dir != last_dir && last_duty != 0 && cfg.dead_ticks != 0) begin
            bridge    = BRIDGE_COAST;
            dead_left = cfg.dead_ticks;
            pend_duty = duty;
            pend_dir  = dir;
            return;
        end
        apply_cmd(duty, dir);
    endfunction

    function automatic void tick_once();
        // Dead time holds the move countdown
        if (dead_left != 0) begin
            dead_left = dead_left - 1'b1;
            if (dead_left == 0)
                apply_cmd(pend_duty, pend_dir);
            return;
        end
        if (move_armed) begin
            if (move_left != 0)
                move_left = move_left - 1'b1;
            if (move_left == 0)
                stop_all();
        end
    endfunction

    function automatic t_bridge_view predict_view(t_mode mode,
                                                  logic signed [SPEED_W-1:0] spd,
                                                  logic dir,
                                                  logic signed [AMOUNT_W-1:0] amt,
                                                  logic add_home);
        logic [HOME_W-1:0] run_us;
        t_bridge_view      view;
        if (cfg.enable) begin
            case (mode)
                MODE_DRIVE: begin
                    drive_cmd(clamp_duty(spd), dir);
                end
                MODE_MOVE: begin
                    run_us = move_time_us(amt, add_home);
                    if (run_us == 0) begin
                        stop_all();
                    end else begin
                        drive_cmd(clamp_duty(spd), dir);
                        move_left  = run_us;
                        move_armed = 1'b1;
                    end
                end
                MODE_STOP: begin
                    stop_all();
                end
                default: begin
                    tick_once();
                end
            endcase
        end
        view.dead_time_active = (dead_left != 0);
        view.line_one = !view.dead_time_active && bridge == BRIDGE_ONE;
        view.line_two = !view.dead_time_active && bridge == BRIDGE_TWO;
        view.duty     = (view.line_one || view.line_two) ? last_duty : '0;
        view.move_active = move_armed;
        return view;
    endfunction

    task automatic check_field(string name, logic [DUTY_W-1:0] want, logic [DUTY_W-1:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endtask

    // Track config writes, predict on each command transfer, compare each result
    always @(posedge i_clk) begin
        t_bridge_view want;
        if (!i_rst_n) begin
            cfg.enable      = RST_ENABLE;
            cfg.max_amount  = RST_MAX_AMOUNT;
            cfg.us_per_unit = RST_US_PER_UNIT;
            cfg.home_us     = RST_HOME_US;
            cfg.dead_ticks  = RST_DEAD_TICKS;
            last_dir  = 1'b0;
            stop_all();
            expected_views.delete();
            waiting = 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg_idx'(i_paddr[CFG_ADDR_W-1:2]))
                    REG_ENABLE:      cfg.enable      = i_pwdata[0];
                    REG_MAX_AMOUNT:  cfg.max_amount  = i_pwdata[MAXAMT_W-1:0];
                    REG_US_PER_UNIT: cfg.us_per_unit = i_pwdata[RATE_W-1:0];
                    REG_HOME_US:     cfg.home_us     = i_pwdata[HOME_W-1:0];
                    REG_DEAD_TICKS:  cfg.dead_ticks  = i_pwdata[DEAD_W-1:0];
                    default: ;
                endcase
            end
            if (i_out.valid && i_out.ready) begin
                if (expected_views.size() == 0) begin
                    $error("result transfer with no command outstanding");
                    fails++;
                end else begin
                    want = expected_views.pop_front();
                    check_field("line_one", want.line_one, i_out.line_one);
                    check_field("line_two", want.line_two, i_out.line_two);
                    check_field("duty", want.duty, i_out.duty);
                    check_field("dead_time_active", want.dead_time_active,
                                i_out.dead_time_active);
                    check_field("move_active", want.move_active, i_out.move_active);
                end
            end
            if (i_in.valid && i_in.ready)
                expected_views.push_back(predict_view(t_mode'(i_in.mode), i_in.speed,
                                                      i_in.direction, i_in.amount,
                                                      i_in.add_home));
            waiting = expected_views.size();
        end
    end

    initial begin
        fails   = 0;
        waiting = 0;
    end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 100ps
// Testbench top of the H-bridge drive: clock, reset, config writes and command
// stimulus with random idling. Needs thbd_pkg, thbd_tb_pkg, thbd_if and thbd_checker.
module tb;
    import thbd_pkg::*;
    import thbd_tb_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 6;
    localparam int ITEM_TARGET   = 1550;
    localparam int PHASE_ITEMS   = 130;
    localparam int OFF_ITEMS     = 16;
    localparam int OFF_PHASE     = 3;
    localparam int HOLD_CYCLES   = 80;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 400000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    int fail_count;
    int pending;
    int snd_idle;
    int rcv_idle;
    int items_sent;
    bit counting;
    int hold_req;
    int hold_seen;
    int hold_left;
    int cycles = 0;

    thbd_in_if  cmd_ch();
    thbd_out_if bridge_ch();

    timed_hbridge_drive_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_ch),
        .o_out   (bridge_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    thbd_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (cmd_ch),
        .i_out        (bridge_ch),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Bound the run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Result side: random stalls, plus one long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            bridge_ch.ready <= 1'b0;
        end else if (hold_left != 0) begin
            bridge_ch.ready <= 1'b0;
            hold_left       <= hold_left - 1;
        end else if (hold_seen != hold_req) begin
            hold_seen       <= hold_req;
            hold_left       <= HOLD_CYCLES;
            bridge_ch.ready <= 1'b0;
        end else begin
            bridge_ch.ready <= ($urandom_range(99) >= rcv_idle);
        end
    end

    task automatic apb_write(t_reg_idx idx, logic [CFG_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_config(logic en, logic [MAXAMT_W-1:0] max_amt,
                              logic [RATE_W-1:0] rate, logic [HOME_W-1:0] home,
                              logic [DEAD_W-1:0] dead);
        apply_write: begin
            apb_write(REG_ENABLE, CFG_DATA_W'(en));
            apb_write(REG_MAX_AMOUNT, CFG_DATA_W'(max_amt));
            apb_write(REG_US_PER_UNIT, CFG_DATA_W'(rate));
            apb_write(REG_HOME_US, CFG_DATA_W'(home));
            apb_write(REG_DEAD_TICKS, CFG_DATA_W'(dead));
        end
    endtask

    // Idling pattern follows progress; trigger the long hold-off once
    task automatic update_idling();
        if (items_sent < ITEM_TARGET / 3) begin
            snd_idle = 27;
            rcv_idle = 51;
        end else if (items_sent < 2 * ITEM_TARGET / 3) begin
            snd_idle = 51;
            rcv_idle = 27;
        end else begin
            snd_idle = 0;
            rcv_idle = 0;
        end
        if (counting && items_sent == 2 * ITEM_TARGET / 3 + 20)
            hold_req++;
    endtask

    task automatic send_item(t_mode mode, logic signed [SPEED_W-1:0] spd, logic dir,
                             logic signed [AMOUNT_W-1:0] amt, logic add_home);
        update_idling();
        while ($urandom_range(99) < snd_idle) begin
            cmd_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_ch.valid     <= 1'b1;
        cmd_ch.mode      <= mode;
        cmd_ch.speed     <= spd;
        cmd_ch.direction <= dir;
        cmd_ch.amount    <= amt;
        cmd_ch.add_home  <= add_home;
        do @(posedge i_clk); while (!cmd_ch.ready);
        if (counting)
            items_sent++;
    endtask

    // Drop valid and wait until every result has arrived
    task automatic wait_idle();
        cmd_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Mostly ticks with commands in between, some items fully random
    task automatic send_random();
        logic [SPEED_W-1:0]  spd;
        logic [AMOUNT_W-1:0] amt;
        int                  pick;
        t_mode               mode;
        pick = $urandom_range(99);
        spd  = ($urandom_range(3) == 0) ? SPEED_W'($urandom) : SPEED_W'($urandom_range(300));
        case ($urandom_range(9))
            0:       amt = '0;
            1, 2:    amt = AMOUNT_W'($urandom);
            default: amt = AMOUNT_W'($urandom_range(200, 1));
        endcase
        if (pick < 58)
            mode = MODE_TICK;
        else if (pick < 73)
            mode = MODE_DRIVE;
        else if (pick < 85)
            mode = MODE_MOVE;
        else if (pick < 88)
            mode = MODE_STOP;
        else
            mode = t_mode'($urandom_range(3));
        send_item(mode, spd, 1'($urandom_range(1)), amt, 1'($urandom_range(1)));
    endtask

    // First two phases take the extremes, the rest mix small and edge values
    task automatic random_config(int phase);
        logic [MAXAMT_W-1:0] max_amt;
        logic [RATE_W-1:0]   rate;
        logic [HOME_W-1:0]   home;
        logic [DEAD_W-1:0]   dead;
        case ($urandom_range(9))
            0:       max_amt = '0;
            1:       max_amt = '1;
            default: max_amt = MAXAMT_W'($urandom_range(1024, 1));
        endcase
        case ($urandom_range(9))
            0:       rate = '0;
            1:       rate = '1;
            default: rate = RATE_W'($urandom_range(40, 1));
        endcase
        case ($urandom_range(9))
            0:          home = '1;
            1:          home = $urandom;
            2, 3, 4:    home = HOME_W'($urandom_range(40, 1));
            default:    home = '0;
        endcase
        case ($urandom_range(9))
            0:       dead = '0;
            1:       dead = '1;
            default: dead = DEAD_W'($urandom_range(12, 1));
        endcase
        if (phase == 0)
            set_config(1'b1, '1, '1, '1, '1);
        else if (phase == 1)
            set_config(1'b1, '0, '0, '0, '0);
        else
            set_config(phase != OFF_PHASE, max_amt, rate, home, dead);
    endtask

    initial begin
        int phase;
        int n_items;
        i_clk            = 1'b0;
        i_rst_n          = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        cmd_ch.valid     = 1'b0;
        cmd_ch.mode      = MODE_DRIVE;
        cmd_ch.speed     = '0;
        cmd_ch.direction = 1'b0;
        cmd_ch.amount    = '0;
        cmd_ch.add_home  = 1'b0;
        bridge_ch.ready  = 1'b0;
        hold_req         = 0;
        hold_seen        = 0;
        hold_left        = 0;
        items_sent       = 0;
        counting         = 1'b1;
        snd_idle         = 0;
        rcv_idle         = 0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: speed clamps, reversal into dead time, zero-total moves
        send_item(MODE_DRIVE, 16'sd100, 1'b1, '0, 1'b0);
        send_item(MODE_DRIVE, 16'sh7FFF, 1'b1, '0, 1'b0);
        send_item(MODE_DRIVE, 16'sh8000, 1'b1, '0, 1'b0);
        send_item(MODE_DRIVE, 16'sd255, 1'b0, '0, 1'b0);
        send_item(MODE_DRIVE, 16'sd256, 1'b1, '0, 1'b0);
        send_item(MODE_DRIVE, 16'sd7, 1'b0, '0, 1'b0);
        send_item(MODE_TICK, '0, 1'b0, '0, 1'b0);
        send_item(MODE_MOVE, 16'sd20, 1'b1, '0, 1'b0);
        send_item(MODE_MOVE, 16'sd20, 1'b1, 16'sh8000, 1'b1);
        send_item(MODE_MOVE, 16'sd40, 1'b1, 16'sh7FFF, 1'b0);
        send_item(MODE_STOP, 16'shFFFF, 1'b1, 16'shFFFF, 1'b1);
        wait_idle();

        // Saturating move, reversal while armed, countdown held through dead time
        set_config(1'b1, '1, '1, '1, 16'd2);
        send_item(MODE_MOVE, 16'sd9, 1'b1, 16'sh7FFF, 1'b1);
        send_item(MODE_DRIVE, 16'sd50, 1'b0, '0, 1'b0);
        send_item(MODE_DRIVE, 16'sd60, 1'b1, '0, 1'b0);
        send_item(MODE_TICK, '0, 1'b0, '0, 1'b0);
        send_item(MODE_TICK, '0, 1'b0, '0, 1'b0);
        send_item(MODE_TICK, '0, 1'b0, '0, 1'b0);
        send_item(MODE_MOVE, 16'sd3, 1'b1, 16'sd1, 1'b0);
        send_item(MODE_STOP, '0, 1'b0, '0, 1'b0);
        wait_idle();

        // No dead time: instant reversal, short move running out, amount clamp
        set_config(1'b1, 15'd3, 24'd256, '0, '0);
        send_item(MODE_DRIVE, 16'sd30, 1'b1, '0, 1'b0);
        send_item(MODE_DRIVE, 16'sd30, 1'b0, '0, 1'b0);
        send_item(MODE_MOVE, 16'sd5, 1'b0, 16'sd2, 1'b0);
        send_item(MODE_TICK, '0, 1'b0, '0, 1'b0);
        send_item(MODE_TICK, '0, 1'b0, '0, 1'b0);
        send_item(MODE_MOVE, 16'sd5, 1'b1, 16'sd100, 1'b0);

        // Random phases, one of them with the driver switched off
        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            wait_idle();
            random_config(phase);
            counting = (phase != OFF_PHASE);
            n_items  = (phase == OFF_PHASE) ? OFF_ITEMS : PHASE_ITEMS;
            for (int i = 0; i < n_items && items_sent < ITEM_TARGET; i++)
                send_random();
            phase++;
        end
        counting = 1'b1;
        wait_idle();

        if (fail_count == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

### filelist.f
+incdir+hdl
hdl/thbd_pkg.sv
hdl/thbd_if.sv
hdl/thbd_regs.sv
hdl/thbd_move.sv
hdl/thbd_ctrl.sv
hdl/timed_hbridge_drive_top.sv
tb/sv/thbd_tb_pkg.sv
tb/sv/thbd_checker.sv
tb/sv/tb.sv
